// ----- src/fwsi_pkg.sv -----
// ----------------------------------------------------------------------------
// fwsi_pkg
// Shared types and constants for the circular queue with sorted insert.
// ----------------------------------------------------------------------------
package fwsi_pkg;

    localparam int DEPTH   = 64;                 // must be a power of two
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 8;
    localparam int COUNT_W = 7;                  // width of the result count field

    // operation codes
    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_PEEK   = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [DATA_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] head_value;
        logic [1:0]               status;
        logic [COUNT_W-1:0]       count;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CMP,
        ST_HEAD,
        ST_FINISH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture accepted item
        logic rd_head;     // read entry at head
        logic rd_scan;     // read entry at ring(k-1)
        logic wr_tail;     // write value at tail
        logic wr_value_k;  // write value at ring(k)
        logic wr_shift;    // move read entry to ring(k), k--
        logic push;        // count++, tail++
        logic pop;         // count--, head++
        logic set_full;
        logic set_empty;
        logic take_head;   // capture read entry as head_value
        logic deliver;     // load output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_append;
        logic is_insert;
        logic is_remove;
        logic full;
        logic empty;
        logic k_zero;
        logic larger;      // read entry > value
        logic slot_free;   // output register can take a result
    } sts_t;

endpackage

// ----- src/fifo_with_sorted_insert_unit.sv -----
// ----------------------------------------------------------------------------
// fifo_with_sorted_insert_unit
// Circular byte queue with append, sorted insert, remove and peek.
// ----------------------------------------------------------------------------
// Sequence: each transfer is taken in IDLE. Append and failed operations go
// from EXEC to FINISH, and remove/peek go through HEAD. A sorted insert loops
// EXEC/CMP once per moved entry until it finds its slot or reaches the head. Each
// scan step is one RAM read then one RAM write. One item at a time; the next
// transfer is taken only after the result is loaded into the output register,
// which waits while the output stalls. Reset empties the queue; RAM contents are not reset.
// ----------------------------------------------------------------------------
module fifo_with_sorted_insert_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  fwsi_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output fwsi_pkg::result_t result
);

    fwsi_pkg::cmd_t cmd;
    fwsi_pkg::sts_t sts;

    fwsi_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    fwsi_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

    a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push && cmd.pop))
        else $error("push and pop in the same cycle");

    a_deliver_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.deliver |-> sts.slot_free)
        else $error("result loaded over a pending transfer");

    a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_shift |-> !sts.k_zero)
        else $error("insert scan moved past the head");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("second item taken while one is in progress");

endmodule

// ----- src/fwsi_ram.sv -----
// ----------------------------------------------------------------------------
// fwsi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fwsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/fwsi_dp.sv -----
// ----------------------------------------------------------------------------
// fwsi_dp
// Datapath: ring pointers, count, scan index, entry RAM and result register.
// ----------------------------------------------------------------------------
module fwsi_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  fwsi_pkg::item_t   item,
    input  fwsi_pkg::cmd_t    cmd,
    output fwsi_pkg::sts_t    sts,
    input  logic              result_stall,
    output logic              result_valid,
    output fwsi_pkg::result_t result
);

    logic [1:0]                         mode_reg;
    logic signed [fwsi_pkg::DATA_W-1:0] value_reg;
    logic [fwsi_pkg::CNT_W-1:0]         k_reg;
    logic [fwsi_pkg::ADDR_W-1:0]        head_reg, head_next;
    logic [fwsi_pkg::ADDR_W-1:0]        tail_reg, tail_next;
    logic [fwsi_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [fwsi_pkg::DATA_W-1:0] hv_reg;
    logic [1:0]                         status_reg;
    logic                               valid_reg, valid_next;
    fwsi_pkg::result_t                  out_reg;

    logic [fwsi_pkg::ADDR_W-1:0]        pos_k, pos_km1;
    logic                               we, re;
    logic [fwsi_pkg::ADDR_W-1:0]        waddr, raddr;
    logic [fwsi_pkg::DATA_W-1:0]        wdata, rdata;
    logic signed [fwsi_pkg::DATA_W-1:0] rdata_s;

    // ring order positions; depth is a power of two so the add wraps
    assign pos_k   = head_reg + k_reg[fwsi_pkg::ADDR_W-1:0];
    assign pos_km1 = pos_k - fwsi_pkg::ADDR_W'(1);
    assign rdata_s = rdata;

    always_comb
    begin
        we    = cmd.wr_tail | cmd.wr_value_k | cmd.wr_shift;
        waddr = cmd.wr_tail ? tail_reg : pos_k;
        wdata = cmd.wr_shift ? rdata : value_reg;
        re    = cmd.rd_head | cmd.rd_scan;
        raddr = cmd.rd_head ? head_reg : pos_km1;
    end

    fwsi_ram #(
        .WIDTH (fwsi_pkg::DATA_W),
        .DEPTH (fwsi_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // item, scan, status, head value and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= item.mode;
            value_reg <= item.value;
            k_reg     <= cnt_reg;
            hv_reg    <= '0;
            status_reg <= fwsi_pkg::STATUS_OK;
        end
        else
        begin
            if (cmd.wr_shift)
            begin
                k_reg <= k_reg - fwsi_pkg::CNT_W'(1);
            end
            if (cmd.set_full)
            begin
                status_reg <= fwsi_pkg::STATUS_FULL;
            end
            if (cmd.set_empty)
            begin
                status_reg <= fwsi_pkg::STATUS_EMPTY;
            end
            if (cmd.take_head)
            begin
                hv_reg <= rdata_s;
            end
        end
        if (cmd.deliver)
        begin
            out_reg.head_value <= hv_reg;
            out_reg.status     <= status_reg;
            out_reg.count      <= fwsi_pkg::COUNT_W'(cnt_reg);
        end
    end

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        if (cmd.push)
        begin
            tail_next = tail_reg + fwsi_pkg::ADDR_W'(1);
            cnt_next  = cnt_reg + fwsi_pkg::CNT_W'(1);
        end
        if (cmd.pop)
        begin
            head_next = head_reg + fwsi_pkg::ADDR_W'(1);
            cnt_next  = cnt_reg - fwsi_pkg::CNT_W'(1);
        end
        if (cmd.deliver)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        sts.is_append = (mode_reg == fwsi_pkg::MODE_APPEND);
        sts.is_insert = (mode_reg == fwsi_pkg::MODE_INSERT);
        sts.is_remove = (mode_reg == fwsi_pkg::MODE_REMOVE);
        sts.full      = (cnt_reg >= fwsi_pkg::CNT_W'(fwsi_pkg::DEPTH));
        sts.empty     = (cnt_reg == '0);
        sts.k_zero    = (k_reg == '0);
        sts.larger    = (rdata_s > value_reg);
        sts.slot_free = !valid_reg || !result_stall;
    end

    assign result_valid = valid_reg;
    assign result       = out_reg;

endmodule

// ----- src/fwsi_ctrl.sv -----
// ----------------------------------------------------------------------------
// fwsi_ctrl
// Controller: sequences queue operations and the sorted-insert scan.
// ----------------------------------------------------------------------------
module fwsi_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  fwsi_pkg::sts_t sts,
    output fwsi_pkg::cmd_t cmd
);

    fwsi_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fwsi_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fwsi_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = fwsi_pkg::ST_EXEC;
                end
            end
            fwsi_pkg::ST_EXEC:
            begin
                priority if (sts.is_append || sts.is_insert)
                begin
                    if (sts.full || sts.is_append || sts.k_zero)
                    begin
                        state_next = fwsi_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = fwsi_pkg::ST_CMP;
                    end
                end
                else if (sts.empty)
                begin
                    state_next = fwsi_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = fwsi_pkg::ST_HEAD;
                end
            end
            fwsi_pkg::ST_CMP:
            begin
                state_next = sts.larger ? fwsi_pkg::ST_EXEC : fwsi_pkg::ST_FINISH;
            end
            fwsi_pkg::ST_HEAD:
            begin
                state_next = fwsi_pkg::ST_FINISH;
            end
            fwsi_pkg::ST_FINISH:
            begin
                if (sts.slot_free)
                begin
                    state_next = fwsi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fwsi_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_stall = 1'b1;
        unique case (state_reg)
            fwsi_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
                cmd.load   = item_valid;
            end
            fwsi_pkg::ST_EXEC:
            begin
                priority if (sts.is_append || sts.is_insert)
                begin
                    priority if (sts.full)
                    begin
                        cmd.set_full = 1'b1;
                    end
                    else if (sts.is_append)
                    begin
                        cmd.wr_tail = 1'b1;
                        cmd.push    = 1'b1;
                    end
                    else if (sts.k_zero)
                    begin
                        // scan reached the head: value goes first
                        cmd.wr_value_k = 1'b1;
                        cmd.push       = 1'b1;
                    end
                    else
                    begin
                        cmd.rd_scan = 1'b1;
                    end
                end
                else if (sts.empty)
                begin
                    cmd.set_empty = 1'b1;
                end
                else
                begin
                    cmd.rd_head = 1'b1;
                end
            end
            fwsi_pkg::ST_CMP:
            begin
                if (sts.larger)
                begin
                    cmd.wr_shift = 1'b1;
                end
                else
                begin
                    cmd.wr_value_k = 1'b1;
                    cmd.push       = 1'b1;
                end
            end
            fwsi_pkg::ST_HEAD:
            begin
                cmd.take_head = 1'b1;
                cmd.pop       = sts.is_remove;
            end
            fwsi_pkg::ST_FINISH:
            begin
                cmd.deliver = sts.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- tb/fifo_with_sorted_insert_unit_tb.sv -----
// ----------------------------------------------------------------------------
// fifo_with_sorted_insert_unit_tb
// Self-checking bench for the circular byte queue with sorted insert. A
// scoreboard object mirrors the ring (head, tail, fill level, entries),
// predicts one result per input transfer and checks every output transfer
// field by field. Stimulus: directed corner cases, a fill to full under a
// long output hold-off, a full drain, then biased random segments.
// ----------------------------------------------------------------------------
module fifo_with_sorted_insert_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_TOTAL    = 400;
    localparam int HOLD_OFF       = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    class sorted_queue_model;
        logic signed [fwsi_pkg::DATA_W-1:0] cells [fwsi_pkg::DEPTH];
        int head_pos;
        int tail_pos;
        int fill_level;
        fwsi_pkg::result_t queued_outcomes [$];
        int mismatches;

        function new();
            foreach (cells[i])
            begin
                cells[i] = '0;
            end
            head_pos   = 0;
            tail_pos   = 0;
            fill_level = 0;
            mismatches = 0;
        endfunction

        function int slot(int ofs);
            return (head_pos + ofs) % fwsi_pkg::DEPTH;
        endfunction

        // apply one operation to the mirrored ring and queue its outcome
        function void take_item(fwsi_pkg::item_t it);
            fwsi_pkg::result_t r;
            int k;
            r = '0;
            if (it.mode == fwsi_pkg::MODE_APPEND || it.mode == fwsi_pkg::MODE_INSERT)
            begin
                if (fill_level >= fwsi_pkg::DEPTH)
                begin
                    r.status = fwsi_pkg::STATUS_FULL;
                end
                else
                begin
                    if (it.mode == fwsi_pkg::MODE_APPEND)
                    begin
                        cells[tail_pos] = it.value;
                    end
                    else
                    begin
                        // walk from newest toward oldest, moving larger entries back
                        k = fill_level;
                        while (k > 0 && $signed(it.value) < $signed(cells[slot(k - 1)]))
                        begin
                            cells[slot(k)] = cells[slot(k - 1)];
                            k--;
                        end
                        cells[slot(k)] = it.value;
                    end
                    tail_pos = (tail_pos + 1) % fwsi_pkg::DEPTH;
                    fill_level++;
                end
            end
            else
            begin
                if (fill_level == 0)
                begin
                    r.status = fwsi_pkg::STATUS_EMPTY;
                end
                else
                begin
                    r.head_value = cells[head_pos];
                    if (it.mode == fwsi_pkg::MODE_REMOVE)
                    begin
                        head_pos = (head_pos + 1) % fwsi_pkg::DEPTH;
                        fill_level--;
                    end
                end
            end
            r.count = fwsi_pkg::COUNT_W'(fill_level);
            queued_outcomes.push_back(r);
        endfunction

        function void compare_result(fwsi_pkg::result_t got);
            fwsi_pkg::result_t want;
            if (queued_outcomes.size() == 0)
            begin
                $error("unexpected result: head_value %0d status %0d count %0d",
                       got.head_value, got.status, got.count);
                mismatches++;
                return;
            end
            want = queued_outcomes.pop_front();
            if (got.head_value !== want.head_value)
            begin
                $error("head_value: expected %0d, actual %0d", want.head_value, got.head_value);
                mismatches++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
            if (got.count !== want.count)
            begin
                $error("count: expected %0d, actual %0d", want.count, got.count);
                mismatches++;
            end
        endfunction
    endclass

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    fwsi_pkg::item_t   item         = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    fwsi_pkg::result_t result;

    sorted_queue_model model = new();
    int  items_sent   = 0;
    int  burst_left   = 0;
    int  quiet_cycles = 0;
    bit  hold_off_req = 1'b0;

    fifo_with_sorted_insert_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic logic signed [fwsi_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 8'sd127;
            1:       return -8'sd128;
            2:       return fwsi_pkg::DATA_W'($urandom_range(0, 3));   // near-equal values
            default: return fwsi_pkg::DATA_W'($urandom);
        endcase
    endfunction

    task automatic idle_for(int n);
        @(negedge clk);
        item_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // burst/gap pacing of the sender
    task automatic pace();
        if (burst_left > 0)
        begin
            burst_left--;
        end
        if (burst_left == 0)
        begin
            idle_for($urandom_range(1, 6));
            if ($urandom_range(0, 3) == 0)
            begin
                burst_left = $urandom_range(40, 80);
            end
            else
            begin
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    task automatic send_item(logic [1:0] mode, logic signed [fwsi_pkg::DATA_W-1:0] value);
        fwsi_pkg::item_t it;
        it.mode  = mode;
        it.value = value;
        @(negedge clk);
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (item_stall);
        model.take_item(it);
        items_sent++;
        pace();
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_valid <= 1'b0;
        while (model.queued_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic run_segment();
        int add_pct;
        int len;
        logic [1:0] mode;
        case ($urandom_range(0, 2))
            0:       add_pct = 85;
            1:       add_pct = 50;
            default: add_pct = 15;
        endcase
        len = $urandom_range(10, 60);
        repeat (len)
        begin
            if ($urandom_range(1, 100) <= add_pct)
            begin
                mode = ($urandom_range(0, 9) < 7) ? fwsi_pkg::MODE_INSERT
                                                  : fwsi_pkg::MODE_APPEND;
            end
            else
            begin
                mode = ($urandom_range(0, 4) < 3) ? fwsi_pkg::MODE_REMOVE
                                                  : fwsi_pkg::MODE_PEEK;
            end
            send_item(mode, pick_value());
        end
    endtask

    // receiver stall pattern, with an on-demand long hold-off
    initial
    begin
        int style;
        int span;
        int hold_left;
        hold_left = 0;
        style     = 0;
        span      = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (span == 0)
            begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(30, 200);
            end
            span--;
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_OFF - 1;
                result_stall <= 1'b1;
            end
            else
            begin
                case (style)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 3) == 0);
                    2:       result_stall <= ($urandom_range(0, 3) != 0);
                    default: result_stall <= ~result_stall;
                endcase
            end
        end
    end

    // output monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                model.compare_result(result);
            end
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("FAIL fifo_with_sorted_insert_unit");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // empty queue, extremes, equal values, every operation
        send_item(fwsi_pkg::MODE_PEEK,   8'sd0);
        send_item(fwsi_pkg::MODE_REMOVE, 8'sd0);
        send_item(fwsi_pkg::MODE_APPEND, 8'sd127);
        send_item(fwsi_pkg::MODE_APPEND, -8'sd128);
        send_item(fwsi_pkg::MODE_INSERT, 8'sd0);
        send_item(fwsi_pkg::MODE_INSERT, 8'sd0);
        send_item(fwsi_pkg::MODE_INSERT, -8'sd128);
        send_item(fwsi_pkg::MODE_INSERT, 8'sd127);
        send_item(fwsi_pkg::MODE_INSERT, -8'sd1);
        send_item(fwsi_pkg::MODE_PEEK,   8'sd5);
        send_item(fwsi_pkg::MODE_REMOVE, 8'sd0);
        send_item(fwsi_pkg::MODE_REMOVE, 8'sd0);
        send_item(fwsi_pkg::MODE_APPEND, 8'sh55);
        send_item(fwsi_pkg::MODE_INSERT, -8'sh56);
        send_item(fwsi_pkg::MODE_INSERT, 8'sd1);
        send_item(fwsi_pkg::MODE_INSERT, 8'sd1);
        send_item(fwsi_pkg::MODE_PEEK,   -8'sd1);
        while (model.fill_level > 0)
        begin
            send_item(fwsi_pkg::MODE_REMOVE, 8'sd0);
        end
        send_item(fwsi_pkg::MODE_PEEK,   8'sd0);
        send_item(fwsi_pkg::MODE_INSERT, -8'sd128);
        send_item(fwsi_pkg::MODE_REMOVE, 8'sd0);
        wait_drained();

        // fill to full while the output is held off, then push past full
        hold_off_req = 1'b1;
        while (model.fill_level < fwsi_pkg::DEPTH)
        begin
            send_item(fwsi_pkg::MODE_INSERT, pick_value());
        end
        send_item(fwsi_pkg::MODE_INSERT, pick_value());
        send_item(fwsi_pkg::MODE_APPEND, pick_value());
        send_item(fwsi_pkg::MODE_PEEK,   pick_value());
        while (model.fill_level > 0)
        begin
            send_item(fwsi_pkg::MODE_REMOVE, pick_value());
        end
        send_item(fwsi_pkg::MODE_REMOVE, pick_value());
        wait_drained();

        while (items_sent < ITEMS_TOTAL)
        begin
            run_segment();
            if ($urandom_range(0, 5) == 0)
            begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (model.mismatches == 0 && model.queued_outcomes.size() == 0)
        begin
            $display("PASS fifo_with_sorted_insert_unit");
        end
        else
        begin
            $display("FAIL fifo_with_sorted_insert_unit");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/fwsi_pkg.sv
src/fwsi_ram.sv
src/fwsi_dp.sv
src/fwsi_ctrl.sv
src/fifo_with_sorted_insert_unit.sv
tb/fifo_with_sorted_insert_unit_tb.sv
